// ----- sv/sitd_pkg.sv -----
// Shared types and constants of the sorted id table with expiry.
package sitd_pkg;

    localparam int unsigned DEFAULT_DEPTH = 256;
    localparam logic [31:0] LIFE_TIME_RESET = 32'd1800;

    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_LOOKUP  = 2'd1;
    localparam logic [1:0] KIND_REPLACE = 2'd2;
    localparam logic [1:0] KIND_SET_EXP = 2'd3;

    localparam logic CFG_LIFE_TIME = 1'b0;
    localparam logic CFG_CARE_MODE = 1'b1;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] tref;
        logic [31:0] expiry;
    } t_entry;

endpackage

// ----- sv/sorted_id_table_with_expiry.sv -----
// Sorted id table with expiry: top level with table memory and sequencer.
//
// One item is accepted when i_start is high and o_busy is low; its single result
// appears with o_valid for one cycle and cannot be held off. Table reads are
// registered, so each probe of the binary search passes a probe and a compare
// state. A lookup repeats these until the id is found or the range is empty; an
// insert runs the same search, moves each entry above its slot up by one (a read
// and a write state each), then writes the new entry; replace and set expiry use
// a read and a write state; an insert into a full table or an index out of range
// is answered from idle. No clearing pass is needed after reset.
module sorted_id_table_with_expiry
    import sitd_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEFAULT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_template_id,
    input  logic [15:0] i_template_ref,
    input  logic [31:0] i_time_first,
    input  logic [31:0] i_time_end,
    input  logic [7:0]  i_entry_index,
    input  logic [31:0] i_new_expiry,
    output logic        o_valid,
    output logic        o_found,
    output logic [7:0]  o_result_index,
    output logic [15:0] o_result_ref,
    output logic [31:0] o_result_expiry,
    output logic [31:0] o_earliest_expiry,
    output logic [8:0]  o_entry_count,
    output logic        o_table_full
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PROBE = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_SHR   = 3'd3;
    localparam logic [2:0] S_SHW   = 3'd4;
    localparam logic [2:0] S_INS   = 3'd5;
    localparam logic [2:0] S_IDXRD = 3'd6;
    localparam logic [2:0] S_IDXWR = 3'd7;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd;

    logic [2:0]  r_state, n_state;
    logic [1:0]  r_kind, n_kind;
    logic [15:0] r_id, n_id;
    logic [15:0] r_ref, n_ref;
    logic [31:0] r_exp, n_exp;
    logic [CW-1:0] r_lo, n_lo, r_hi1, n_hi1, r_k, n_k, r_count, n_count;
    logic [31:0] r_earliest, n_earliest;
    logic [31:0] r_life;
    logic        r_care;
    logic        r_valid, n_valid, r_found, n_found, r_full, n_full;
    logic [7:0]  r_ridx, n_ridx;
    logic [15:0] r_rref, n_rref;
    logic [31:0] r_rexp, n_rexp;

    logic [AW-1:0] rd_addr, wr_addr, mid;
    logic          mem_we;
    t_entry        wr_data;
    logic [CW:0]   mid_sum;
    logic [31:0]   add_base, sat_sum, ins_exp;
    logic [32:0]   add_full;
    t_entry        upd;

    // The one saturating adder, shared by insert and replace.
    always_comb begin
        add_base = (i_kind == KIND_INSERT && r_care) ? i_time_first : i_time_end;
        add_full = {1'b0, add_base} + {1'b0, r_life};
        sat_sum  = add_full[32] ? 32'hFFFF_FFFF : add_full[31:0];
        ins_exp  = (!r_care && i_time_end == 32'd0) ? 32'd0 : sat_sum;
        mid_sum  = {1'b0, r_lo} + {1'b0, r_hi1} - (CW + 1)'(1);
        mid      = AW'(mid_sum >> 1);
    end

    always_comb begin
        n_state = r_state;  n_kind = r_kind;  n_id = r_id;  n_ref = r_ref;
        n_exp = r_exp;  n_lo = r_lo;  n_hi1 = r_hi1;  n_k = r_k;
        n_count = r_count;  n_earliest = r_earliest;
        n_valid = 1'b0;  n_found = r_found;  n_full = r_full;
        n_ridx = r_ridx;  n_rref = r_rref;  n_rexp = r_rexp;
        rd_addr = mid;  wr_addr = AW'(r_lo);  mem_we = 1'b0;
        wr_data = '{id: r_id, tref: r_ref, expiry: r_exp};
        upd = r_rd;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_kind = i_kind;  n_id = i_template_id;  n_ref = i_template_ref;
                    n_lo = '0;  n_hi1 = r_count;
                    n_found = 1'b0;  n_full = 1'b0;
                    n_ridx = '0;  n_rref = '0;  n_rexp = '0;
                    case (i_kind)
                        KIND_INSERT: begin
                            n_exp = ins_exp;
                            if (32'(r_count) >= 32'(TABLE_DEPTH)) begin
                                n_full = 1'b1;
                                n_valid = 1'b1;
                            end else begin
                                if (ins_exp < r_earliest || r_earliest == 32'd0) begin
                                    n_earliest = ins_exp;
                                end
                                n_state = S_PROBE;
                            end
                        end
                        KIND_LOOKUP: begin
                            n_state = S_PROBE;
                        end
                        default: begin
                            n_exp = (i_kind == KIND_REPLACE) ? sat_sum : i_new_expiry;
                            if (32'(i_entry_index) < 32'(r_count)) begin
                                n_k = CW'(i_entry_index);
                                n_state = S_IDXRD;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_PROBE: begin
                if (r_lo < r_hi1) begin
                    n_state = S_CMP;
                end else if (r_kind == KIND_LOOKUP) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_k = r_count;
                    n_state = (r_count > r_lo) ? S_SHR : S_INS;
                end
            end
            S_CMP: begin
                n_state = S_PROBE;
                if (r_kind == KIND_LOOKUP) begin
                    if (r_rd.id == r_id) begin
                        n_found = 1'b1;
                        n_ridx = 8'(mid);
                        n_rref = r_rd.tref;
                        n_rexp = r_rd.expiry;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else if (r_rd.id < r_id) begin
                        n_lo = CW'(mid) + CW'(1);
                    end else begin
                        n_hi1 = CW'(mid);
                    end
                end else begin
                    // Insert goes after every entry with an equal id.
                    if (r_rd.id <= r_id) begin
                        n_lo = CW'(mid) + CW'(1);
                    end else begin
                        n_hi1 = CW'(mid);
                    end
                end
            end
            S_SHR: begin
                rd_addr = AW'(r_k - CW'(1));
                n_state = S_SHW;
            end
            S_SHW: begin
                mem_we = 1'b1;
                wr_addr = AW'(r_k);
                wr_data = r_rd;
                n_k = r_k - CW'(1);
                n_state = (r_k - CW'(1) == r_lo) ? S_INS : S_SHR;
            end
            S_INS: begin
                mem_we = 1'b1;
                n_count = r_count + CW'(1);
                n_found = 1'b1;
                n_ridx = 8'(r_lo);
                n_rref = r_ref;
                n_rexp = r_exp;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_IDXRD: begin
                rd_addr = AW'(r_k);
                n_state = S_IDXWR;
            end
            S_IDXWR: begin
                upd.tref = r_ref;
                if (r_kind == KIND_SET_EXP || r_rd.expiry == 32'd0) begin
                    upd.expiry = r_exp;
                end
                if (r_kind == KIND_SET_EXP) begin
                    upd.tref = r_rd.tref;
                end
                mem_we = 1'b1;
                wr_addr = AW'(r_k);
                wr_data = upd;
                n_found = 1'b1;
                n_ridx = 8'(r_k);
                n_rref = upd.tref;
                n_rexp = upd.expiry;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_earliest <= '0;
            r_valid <= 1'b0;
            r_life <= LIFE_TIME_RESET;
            r_care <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_earliest <= n_earliest;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LIFE_TIME) begin
                    r_life <= i_cfg_data;
                end else begin
                    r_care <= i_cfg_data[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;  r_id <= n_id;  r_ref <= n_ref;  r_exp <= n_exp;
        r_lo <= n_lo;  r_hi1 <= n_hi1;  r_k <= n_k;
        r_found <= n_found;  r_full <= n_full;
        r_ridx <= n_ridx;  r_rref <= n_rref;  r_rexp <= n_rexp;
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_found           = r_found;
    assign o_result_index    = r_ridx;
    assign o_result_ref      = r_rref;
    assign o_result_expiry   = r_rexp;
    assign o_earliest_expiry = r_earliest;
    assign o_entry_count     = 9'(r_count);
    assign o_table_full      = r_full;

endmodule

// ----- sv/sitd_checker.sv -----
// Port-level checks of the sorted id table, bound to the top level.
module sitd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_busy,
    input logic        o_valid,
    input logic        o_found,
    input logic [7:0]  o_result_index,
    input logic [8:0]  o_entry_count,
    input logic        o_table_full
);

    // A result is only shown once the sequencer is back in idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result shown while busy");

    // Every multi-cycle item ends with its result.
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_valid)
        else $error("busy dropped without a result");

    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (!o_found && o_result_index == 8'd0))
        else $error("dropped insert reported as found");

    // The entry count moves only when a result is shown.
    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$stable(o_entry_count) && $past(i_rst_n)) |-> o_valid)
        else $error("entry count changed without a result");

endmodule

bind sorted_id_table_with_expiry sitd_checker u_sitd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_busy         (o_busy),
    .o_valid        (o_valid),
    .o_found        (o_found),
    .o_result_index (o_result_index),
    .o_entry_count  (o_entry_count),
    .o_table_full   (o_table_full)
);

// ----- test/tb_sorted_id_table_with_expiry.sv -----
// Self-checking testbench of the sorted id table with expiry.
`timescale 1ns / 100ps

module tb_sorted_id_table_with_expiry;
    import sitd_pkg::*;

    localparam int DEPTH = 256;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 1100;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] id;
        logic [15:0] tref;
        logic [31:0] t_first;
        logic [31:0] t_end;
        logic [7:0]  idx;
        logic [31:0] nexp;
    } t_op;

    typedef struct packed {
        logic        found;
        logic [7:0]  index;
        logic [15:0] tref;
        logic [31:0] expiry;
        logic [31:0] earliest;
        logic [8:0]  count;
        logic        full;
    } t_res;

    // A directed row; chk_fixed selects a typed-in result instead of the predictor.
    typedef struct packed {
        t_op  op;
        logic chk_fixed;
        t_res res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        i_start = 1'b0;
    logic [1:0]  i_kind = '0;
    logic [15:0] i_template_id = '0;
    logic [15:0] i_template_ref = '0;
    logic [31:0] i_time_first = '0;
    logic [31:0] i_time_end = '0;
    logic [7:0]  i_entry_index = '0;
    logic [31:0] i_new_expiry = '0;
    logic        o_busy, o_valid, o_found, o_table_full;
    logic [7:0]  o_result_index;
    logic [15:0] o_result_ref;
    logic [31:0] o_result_expiry, o_earliest_expiry;
    logic [8:0]  o_entry_count;

    sorted_id_table_with_expiry i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow table.
    logic [15:0] tbl_id[DEPTH];
    logic [15:0] tbl_ref[DEPTH];
    logic [31:0] tbl_exp[DEPTH];
    int          tbl_count;
    logic [31:0] earliest_exp;
    logic [31:0] life_time;
    logic        care_mode;

    t_res expected_q[$];
    int   errors = 0;
    int   idle_cycles = 0;
    logic quiet = 1'b0;

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic t_res table_apply(t_op op);
        t_res r;
        logic [31:0] e;
        int pos, lo, hi, mid;
        r = '0;
        case (op.kind)
            KIND_INSERT: begin
                if (tbl_count >= DEPTH) begin
                    r.full = 1'b1;
                end else begin
                    if (care_mode) e = sat_sum(op.t_first, life_time);
                    else e = (op.t_end != 0) ? sat_sum(op.t_end, life_time) : 32'd0;
                    if (e < earliest_exp || earliest_exp == 0) earliest_exp = e;
                    pos = 0;
                    while (pos < tbl_count && tbl_id[pos] <= op.id) pos++;
                    for (int k = tbl_count; k > pos; k--) begin
                        tbl_id[k] = tbl_id[k-1];
                        tbl_ref[k] = tbl_ref[k-1];
                        tbl_exp[k] = tbl_exp[k-1];
                    end
                    tbl_id[pos] = op.id;
                    tbl_ref[pos] = op.tref;
                    tbl_exp[pos] = e;
                    tbl_count++;
                    r.found = 1'b1;
                    r.index = pos[7:0];
                    r.tref = op.tref;
                    r.expiry = e;
                end
            end
            KIND_LOOKUP: begin
                lo = 0;
                hi = tbl_count - 1;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (tbl_id[mid] == op.id) begin
                        r.found = 1'b1;
                        r.index = mid[7:0];
                        r.tref = tbl_ref[mid];
                        r.expiry = tbl_exp[mid];
                        break;
                    end
                    if (tbl_id[mid] < op.id) lo = mid + 1;
                    else hi = mid - 1;
                end
            end
            default: begin
                if (op.idx < tbl_count) begin
                    if (op.kind == KIND_REPLACE) begin
                        tbl_ref[op.idx] = op.tref;
                        if (tbl_exp[op.idx] == 0)
                            tbl_exp[op.idx] = sat_sum(op.t_end, life_time);
                    end else begin
                        tbl_exp[op.idx] = op.nexp;
                    end
                    r.found = 1'b1;
                    r.index = op.idx;
                    r.tref = tbl_ref[op.idx];
                    r.expiry = tbl_exp[op.idx];
                end
            end
        endcase
        r.earliest = earliest_exp;
        r.count = tbl_count[8:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                e = expected_q.pop_front();
                if (o_found !== e.found) report_mismatch("found", o_found, e.found);
                if (o_result_index !== e.index)
                    report_mismatch("result_index", o_result_index, e.index);
                if (o_result_ref !== e.tref) report_mismatch("result_ref", o_result_ref, e.tref);
                if (o_result_expiry !== e.expiry)
                    report_mismatch("result_expiry", o_result_expiry, e.expiry);
                if (o_earliest_expiry !== e.earliest)
                    report_mismatch("earliest_expiry", o_earliest_expiry, e.earliest);
                if (o_entry_count !== e.count)
                    report_mismatch("entry_count", o_entry_count, e.count);
                if (o_table_full !== e.full)
                    report_mismatch("table_full", o_table_full, e.full);
            end
        end
    end

    // Watchdog: cycles without an accepted item or result.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LIFE_TIME) life_time = data;
        else care_mode = data[0];
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Drive one item; the predicted result is queued when it is accepted.
    // Start stays high after acceptance so the next item can follow at once.
    task automatic issue(t_op op, logic fixed, t_res want);
        t_res p;
        if (!quiet) while ($urandom_range(99) < 7) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_kind <= op.kind;
        i_template_id <= op.id;
        i_template_ref <= op.tref;
        i_time_first <= op.t_first;
        i_time_end <= op.t_end;
        i_entry_index <= op.idx;
        i_new_expiry <= op.nexp;
        do @(posedge i_clk); while (o_busy);
        p = table_apply(op);
        expected_q.push_back(fixed ? want : p);
    endtask

    function automatic logic [31:0] rand_time();
        case ($urandom_range(4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(5000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_op rand_op(int id_span);
        t_op op;
        int c;
        op.id = id_span > 0 ? 16'($urandom_range(id_span)) : 16'($urandom);
        op.tref = 16'($urandom);
        op.t_first = rand_time();
        op.t_end = rand_time();
        op.nexp = rand_time();
        c = $urandom_range(9);
        op.kind = c < 4 ? KIND_INSERT : c < 7 ? KIND_LOOKUP : c < 8 ? KIND_REPLACE : KIND_SET_EXP;
        op.idx = tbl_count > 0 && $urandom_range(9) != 0 ?
                 8'($urandom_range(tbl_count - 1)) : 8'($urandom);
        return op;
    endfunction

    t_row directed[$];

    initial begin
        t_op op;
        life_time = LIFE_TIME_RESET;
        care_mode = 1'b0;
        tbl_count = 0;
        earliest_exp = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: empty table, extremes, duplicates, saturation.
        directed.push_back('{'{KIND_LOOKUP, 16'h0, 0, 0, 0, 0, 0}, 1'b1,
                             '{0, 0, 0, 0, 0, 0, 0}});
        directed.push_back('{'{KIND_REPLACE, 0, 16'h1, 0, 0, 8'h0, 0}, 1'b1,
                             '{0, 0, 0, 0, 0, 0, 0}});
        directed.push_back('{'{KIND_SET_EXP, 0, 0, 0, 0, 8'hFF, 32'h5}, 1'b1,
                             '{0, 0, 0, 0, 0, 0, 0}});
        directed.push_back('{'{KIND_INSERT, 16'h10, 16'hABCD, 0, 32'd0, 0, 0}, 1'b1,
                             '{1, 0, 16'hABCD, 0, 0, 9'd1, 0}});
        directed.push_back('{'{KIND_INSERT, 16'hFFFF, 16'hFFFF, 0, 32'hFFFF_FFFF, 0, 0}, 1'b1,
                             '{1, 8'd1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd2, 0}});
        directed.push_back('{'{KIND_INSERT, 16'h0, 16'h0, 0, 32'd100, 0, 0}, 1'b1,
                             '{1, 0, 0, 32'd1900, 32'd1900, 9'd3, 0}});
        directed.push_back('{'{KIND_INSERT, 16'h10, 16'h2, 0, 32'd7, 0, 0}, 1'b0, '0});
        directed.push_back('{'{KIND_INSERT, 16'h10, 16'h3, 0, 32'd8, 0, 0}, 1'b0, '0});
        directed.push_back('{'{KIND_LOOKUP, 16'h10, 0, 0, 0, 0, 0}, 1'b0, '0});
        directed.push_back('{'{KIND_LOOKUP, 16'hFFFF, 0, 0, 0, 0, 0}, 1'b0, '0});
        directed.push_back('{'{KIND_LOOKUP, 16'h11, 0, 0, 0, 0, 0}, 1'b0, '0});
        directed.push_back('{'{KIND_REPLACE, 0, 16'h5555, 0, 32'hFFFF_FFF0, 8'd1, 0}, 1'b0, '0});
        directed.push_back('{'{KIND_REPLACE, 0, 16'hAAAA, 0, 32'd0, 8'd0, 0}, 1'b0, '0});
        directed.push_back('{'{KIND_SET_EXP, 0, 0, 0, 0, 8'd2, 32'hFFFF_FFFF}, 1'b0, '0});
        directed.push_back('{'{KIND_SET_EXP, 0, 0, 0, 0, 8'd5, 32'h0}, 1'b0, '0});
        directed.push_back('{'{KIND_REPLACE, 0, 0, 0, 0, 8'd5, 0}, 1'b0, '0});
        foreach (directed[i]) issue(directed[i].op, directed[i].chk_fixed, directed[i].res);
        wait_idle();

        // Care-time mode with maximal lifetime saturates on the first time.
        write_reg(CFG_CARE_MODE, 32'd1);
        write_reg(CFG_LIFE_TIME, 32'hFFFF_FFFF);
        issue('{KIND_INSERT, 16'h8000, 16'h1, 32'h1, 32'h0, 0, 0}, 1'b0, '0);
        issue('{KIND_INSERT, 16'h7FFF, 16'h1, 32'h0, 32'h0, 0, 0}, 1'b0, '0);
        wait_idle();
        write_reg(CFG_LIFE_TIME, 32'd0);
        issue('{KIND_INSERT, 16'h8001, 16'h2, 32'h0, 32'h0, 0, 0}, 1'b0, '0);
        wait_idle();

        // Random phases over several settings; fill to full in one phase.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_LIFE_TIME, ph == 1 ? 32'hFFFF_FFFF : ph == 2 ? 32'd0 : $urandom);
            write_reg(CFG_CARE_MODE, {31'd0, ph[0]});
            quiet = (ph == 3);
            for (int n = 0; n < 320; n++) begin
                op = rand_op(ph == 4 ? 0 : 40);
                // Phase five keeps inserting so the table fills and overflows.
                if (ph == 5 && n < 260) op.kind = KIND_INSERT;
                issue(op, 1'b0, '0);
            end
            wait_idle();
        end
        quiet = 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule

// ----- sim.f -----
sv/sitd_pkg.sv
sv/sorted_id_table_with_expiry.sv
sv/sitd_checker.sv
test/tb_sorted_id_table_with_expiry.sv
